FILE: rtl/vm_slot_table_with_vcpu_pinning_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef VM_SLOT_TABLE_WITH_VCPU_PINNING_UNIT_MACROS_SVH
`define VM_SLOT_TABLE_WITH_VCPU_PINNING_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VST_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define VST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/vst_pkg.sv
// Package with the constants, codes and types of the slot table.
package vst_pkg;
   localparam int MaxVms = 16;
   localparam int MaxVcpus = 8;
   localparam int NumCpus = 4;
   localparam int SlotBits = $clog2(MaxVms);
   localparam int CpuBits = 2;
   localparam logic [31:0] HandleBase = 32'h1000;
   localparam logic [8:0] VmidLimit = 9'h0ff;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_TEARDOWN = 2'd1,
      CMD_LOAD = 2'd2,
      CMD_PUT = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_OK = 4'd0,
      ST_FULL = 4'd1,
      ST_EXISTS = 4'd2,
      ST_BAD_COUNT = 4'd3,
      ST_NOT_FOUND = 4'd4,
      ST_BUSY = 4'd5,
      ST_CPU_OCCUPIED = 4'd6,
      ST_ELSEWHERE = 4'd7,
      ST_BAD_INDEX = 4'd8,
      ST_EXHAUSTED = 4'd9
   } status_type;

   // One slot entry as held in the table memory.
   typedef struct packed {
      logic [63:0] owner;
      logic [7:0] vcpus;
      logic [2:0] refs;
      logic [MaxVcpus-1:0] mask;
   } slot_type;

   // Memory port bundle from controller to memory.
   typedef struct packed {
      logic rd_en;
      logic [SlotBits-1:0] rd_addr;
      logic wr_en;
      logic [SlotBits-1:0] wr_addr;
      slot_type wr_data;
   } mem_req_type;
endpackage

FILE: rtl/vst_if.sv
// Valid/ready channel interfaces for requests and responses.
interface vst_req_if;
   import vst_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] cmd;
   logic [63:0] owner_key;
   logic [7:0] vcpu_count;
   logic [31:0] handle;
   logic [7:0] vcpu_index;
   logic [1:0] cpu_index;
   modport source (output valid, cmd, owner_key, vcpu_count, handle, vcpu_index,
      cpu_index, input ready);
   modport sink (input valid, cmd, owner_key, vcpu_count, handle, vcpu_index,
      cpu_index, output ready);
endinterface

interface vst_rsp_if;
   logic valid;
   logic ready;
   logic [3:0] status;
   logic [12:0] handle_out;
   logic [7:0] vmid_out;
   modport source (output valid, status, handle_out, vmid_out, input ready);
   modport sink (input valid, status, handle_out, vmid_out, output ready);
endinterface

FILE: rtl/vm_slot_table_with_vcpu_pinning_unit.sv
// Top level of the guest machine slot table with vcpu pinning.
// Requests arrive on the req channel (cmd, owner_key, vcpu_count, handle,
// vcpu_index, cpu_index); each transaction yields exactly one response
// transaction on the rsp channel (status, handle_out, vmid_out).
// The block handles one request at a time. Slot entries live in a 16-entry
// memory with a registered read; used bits, the allocation pointer and the
// per-cpu pin records sit in flip-flops.
// Steps: an early reject responds in the cycle after acceptance; teardown,
// load and put read the slot, pass through S_EXEC and then respond; an insert
// scans the slots in turn for a duplicate key through the memory read port,
// stopping at a match, and then responds.
// The response holds in its register while rsp ready is low, and no new
// request is taken until it is delivered.
// Reset is synchronous; the used bits clear at once, so stale memory
// contents are never consulted, and the first request is taken once the state
// has passed from S_CLEAR to S_IDLE after reset is released.
module vm_slot_table_with_vcpu_pinning_unit import vst_pkg::*; (
   input logic clock,
   input logic reset,
   vst_req_if.sink req,
   vst_rsp_if.source rsp
);
   mem_req_type mem_req;
   slot_type rd_data;

   vst_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .mem_req(mem_req), .rd_data(rd_data)
   );

   vst_slot_mem u_mem (.clock(clock), .req(mem_req), .rd_data(rd_data));
endmodule

FILE: rtl/vst_slot_mem.sv
// Synchronous slot table memory with one write and one registered read port.
module vst_slot_mem import vst_pkg::*; (
   input logic clock,
   input mem_req_type req,
   output slot_type rd_data
);
   slot_type mem [MaxVms];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end
endmodule

FILE: rtl/vst_ctrl.sv
// Command sequencer: scans and updates the slot memory one entry a cycle.
module vst_ctrl import vst_pkg::*; (
   input logic clock,
   input logic reset,
   vst_req_if.sink req,
   vst_rsp_if.source rsp,
   output mem_req_type mem_req,
   input slot_type rd_data
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_READ, S_EXEC, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [MaxVms-1:0] used_ff, used_in;
   logic [SlotBits-1:0] ptr_ff, ptr_in;
   logic [SlotBits:0] count_ff, count_in;
   logic [NumCpus-1:0] busy_ff, busy_in;
   logic [SlotBits-1:0] cslot_ff [NumCpus];
   logic [SlotBits-1:0] cslot_in [NumCpus];
   logic [2:0] cvcpu_ff [NumCpus];
   logic [2:0] cvcpu_in [NumCpus];
   logic [SlotBits:0] cnt_ff, cnt_in;
   logic [SlotBits-1:0] idx_ff, idx_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [63:0] key_ff, key_in;
   logic [7:0] vc_ff, vc_in;
   logic [7:0] vi_ff, vi_in;
   logic [CpuBits-1:0] cpu_ff, cpu_in;
   logic [3:0] st_ff, st_in;
   logic [12:0] hout_ff, hout_in;
   logic [7:0] vout_ff, vout_in;
   logic [31:0] hoff;
   logic [SlotBits-1:0] scan_idx;
   logic [SlotBits-1:0] free_idx;
   logic free_hit;
   slot_type wdata;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.status = st_ff;
   assign rsp.handle_out = hout_ff;
   assign rsp.vmid_out = vout_ff;
   assign hoff = req.handle - HandleBase;
   assign scan_idx = cnt_ff[SlotBits-1:0];

   // Next-fit free slot search over the used bit vector.
   always_comb begin
      free_idx = ptr_ff;
      free_hit = 1'b0;
      for (int i = MaxVms - 1; i >= 0; i--) begin
         if (!used_ff[ptr_ff + SlotBits'(i)]) begin
            free_idx = ptr_ff + SlotBits'(i);
            free_hit = 1'b1;
         end
      end
   end

   // Sequencer next state and memory requests.
   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      ptr_in = ptr_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      cslot_in = cslot_ff;
      cvcpu_in = cvcpu_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      vc_in = vc_ff;
      vi_in = vi_ff;
      cpu_in = cpu_ff;
      st_in = st_ff;
      hout_in = hout_ff;
      vout_in = vout_ff;
      wdata = rd_data;
      mem_req = '0;
      unique case (state_ff)
         S_CLEAR: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.cmd;
               key_in = req.owner_key;
               vc_in = req.vcpu_count;
               vi_in = req.vcpu_index;
               cpu_in = req.cpu_index;
               hout_in = '0;
               vout_in = '0;
               cnt_in = '0;
               idx_in = hoff[SlotBits-1:0];
               state_in = S_RESP;
               unique case (cmd_type'(req.cmd))
                  CMD_INSERT: begin
                     if (req.vcpu_count < 8'd1 || req.vcpu_count > 8'(MaxVcpus)) begin
                        st_in = ST_BAD_COUNT;
                     end else if (count_ff >= (SlotBits + 1)'(MaxVms)) begin
                        st_in = ST_FULL;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = '0;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_TEARDOWN: begin
                     if (hoff >= 32'(MaxVms) || !used_ff[hoff[SlotBits-1:0]]) begin
                        st_in = ST_NOT_FOUND;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = hoff[SlotBits-1:0];
                        state_in = S_EXEC;
                     end
                  end
                  CMD_LOAD: begin
                     if (busy_ff[req.cpu_index]) begin
                        st_in = ST_CPU_OCCUPIED;
                     end else if (hoff >= 32'(MaxVms) || !used_ff[hoff[SlotBits-1:0]]) begin
                        st_in = ST_NOT_FOUND;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = hoff[SlotBits-1:0];
                        state_in = S_EXEC;
                     end
                  end
                  default: begin
                     if (!busy_ff[req.cpu_index]) begin
                        st_in = ST_EXHAUSTED;
                     end else begin
                        // Keep the pinned vcpu so its mask bit can be dropped.
                        st_in = ST_OK;
                        idx_in = cslot_ff[req.cpu_index];
                        vi_in = 8'(cvcpu_ff[req.cpu_index]);
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = cslot_ff[req.cpu_index];
                        busy_in[req.cpu_index] = 1'b0;
                        cslot_in[req.cpu_index] = '0;
                        cvcpu_in[req.cpu_index] = '0;
                        state_in = S_EXEC;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Duplicate key check, one slot a cycle from the registered read.
            if (used_ff[scan_idx] && rd_data.owner == key_ff) begin
               st_in = ST_EXISTS;
               state_in = S_RESP;
            end else if (cnt_ff == (SlotBits + 1)'(MaxVms - 1)) begin
               state_in = S_RESP;
               ptr_in = free_idx;
               if (!free_hit) begin
                  st_in = ST_FULL;
               end else if ({1'b0, 8'(free_idx)} + 9'd1 > VmidLimit) begin
                  st_in = ST_EXHAUSTED;
               end else begin
                  st_in = ST_OK;
                  mem_req.wr_en = 1'b1;
                  mem_req.wr_addr = free_idx;
                  mem_req.wr_data = '{owner: key_ff, vcpus: vc_ff, refs: '0, mask: '0};
                  used_in[free_idx] = 1'b1;
                  ptr_in = free_idx + SlotBits'(1);
                  count_in = count_ff + 1'b1;
                  hout_in = 13'(HandleBase) + 13'(free_idx);
                  vout_in = 8'(free_idx) + 8'd1;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
               mem_req.rd_en = 1'b1;
               mem_req.rd_addr = scan_idx + SlotBits'(1);
            end
         end
         S_EXEC: begin
            // Load and put read-modify-write the slot; teardown may free it.
            state_in = S_RESP;
            mem_req.wr_addr = idx_ff;
            unique case (cmd_type'(cmd_ff))
               CMD_TEARDOWN: begin
                  if (rd_data.refs != '0) begin
                     st_in = ST_BUSY;
                  end else begin
                     st_in = ST_OK;
                     used_in[idx_ff] = 1'b0;
                     if (count_ff != '0) count_in = count_ff - 1'b1;
                  end
               end
               CMD_LOAD: begin
                  if (vi_ff >= rd_data.vcpus) begin
                     st_in = ST_BAD_INDEX;
                  end else if (rd_data.mask[vi_ff[2:0]]) begin
                     st_in = ST_ELSEWHERE;
                  end else begin
                     st_in = ST_OK;
                     wdata.mask[vi_ff[2:0]] = 1'b1;
                     wdata.refs = rd_data.refs + 3'd1;
                     mem_req.wr_en = 1'b1;
                     mem_req.wr_data = wdata;
                     busy_in[cpu_ff] = 1'b1;
                     cslot_in[cpu_ff] = idx_ff;
                     cvcpu_in[cpu_ff] = vi_ff[2:0];
                  end
               end
               CMD_PUT: begin
                  wdata.mask[vi_ff[2:0]] = 1'b0;
                  if (rd_data.refs != '0) wdata.refs = rd_data.refs - 3'd1;
                  mem_req.wr_en = 1'b1;
                  mem_req.wr_data = wdata;
               end
               default: begin
                  st_in = ST_OK;
               end
            endcase
         end
         S_RESP: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         used_ff <= '0;
         ptr_ff <= '0;
         count_ff <= '0;
         busy_ff <= '0;
         for (int c = 0; c < NumCpus; c++) begin
            cslot_ff[c] <= '0;
            cvcpu_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         ptr_ff <= ptr_in;
         count_ff <= count_in;
         busy_ff <= busy_in;
         cslot_ff <= cslot_in;
         cvcpu_ff <= cvcpu_in;
      end
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      vc_ff <= vc_in;
      vi_ff <= vi_in;
      cpu_ff <= cpu_in;
      st_ff <= st_in;
      hout_ff <= hout_in;
      vout_ff <= vout_in;
   end
endmodule

FILE: rtl/vst_checker.sv
// Port-level checker for the slot table and its bind statement.
`include "vm_slot_table_with_vcpu_pinning_unit_macros.svh"
module vst_checker import vst_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [3:0] rsp_status,
   input logic [12:0] rsp_handle_out
);
   `VST_ASSERT_IMPL(a_one_side, clock, reset, rsp_valid, !req_ready, "ready while response pending")
   `VST_ASSERT_NEXT(a_rsp_after, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `VST_ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_EXHAUSTED, "bad status")
   `VST_ASSERT_IMPL(a_handle_ok, clock, reset, rsp_valid && rsp_handle_out != 13'd0, rsp_status == ST_OK, "handle on failure")
   `VST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
endmodule

bind vm_slot_table_with_vcpu_pinning_unit vst_checker u_vst_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_handle_out(rsp.handle_out)
);
